// ===== hdl/dwssr_pkg.sv =====
// Shared types and constants for the dual wheel step speed regulator.
// Used by the lane, merge and top-level modules; depends on nothing else.
package dwssr_pkg;

    localparam int SPEED_W = 16;
    localparam int TOL_W   = 15;
    localparam int LEVEL_W = 7;
    localparam int IDX_W   = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_LEFT_TARGET   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RIGHT_TARGET  = 3'd1;
    localparam logic [IDX_W-1:0] REG_TOLERANCE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_RUN_THRESHOLD = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEFT_DIR      = 3'd4;
    localparam logic [IDX_W-1:0] REG_RIGHT_DIR     = 3'd5;

    // Per-wheel comparison results handed from a lane to the merge stage.
    typedef struct packed {
        logic above_thr;
        logic below_thr;
        logic too_fast;
        logic too_slow;
    } dwssr_flags_t;

endpackage

// ===== hdl/dwssr_lane.sv =====
// One wheel lane: compares a speed against the run threshold and its target band.
// Depends on dwssr_pkg for widths and the flag struct.
module dwssr_lane
    import dwssr_pkg::*;
(
    input  logic signed [SPEED_W-1:0] speed,
    input  logic signed [SPEED_W-1:0] target,
    input  logic        [TOL_W-1:0]   tolerance,
    input  logic signed [SPEED_W-1:0] run_threshold,
    output dwssr_flags_t              flags
);

    logic signed [SPEED_W:0] diff;
    logic signed [SPEED_W:0] tol_pos;
    logic signed [SPEED_W:0] tol_neg;

    // Signed error against the target, one bit wider so it cannot wrap.
    assign diff    = {speed[SPEED_W-1], speed} - {target[SPEED_W-1], target};
    assign tol_pos = {2'b00, tolerance};
    assign tol_neg = -tol_pos;

    // Threshold and dead-band comparisons.
    always_comb begin
        flags.above_thr = speed > run_threshold;
        flags.below_thr = speed < run_threshold;
        flags.too_fast  = diff > tol_pos;
        flags.too_slow  = diff < tol_neg;
    end

endmodule

// ===== hdl/dwssr_merge.sv =====
// Merge stage: combines both lanes' flags, updates the run latch and levels,
// and holds the result in the output register. Depends on dwssr_pkg.
module dwssr_merge
    import dwssr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  dwssr_flags_t       left_flags,
    input  dwssr_flags_t       right_flags,
    input  logic               left_dir,
    input  logic               right_dir,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] left_duty,
    output logic [LEVEL_W-1:0] right_duty,
    output logic               running
);

    logic               run_reg, run_next;
    logic [LEVEL_W-1:0] left_level_reg, left_level_next;
    logic [LEVEL_W-1:0] right_level_reg, right_level_next;
    logic               valid_reg;
    logic [LEVEL_W-1:0] left_duty_reg, right_duty_reg;
    logic               running_reg;
    logic               take;
    logic               stop;

    function automatic logic [LEVEL_W-1:0] step_level(
        input logic [LEVEL_W-1:0] level,
        input dwssr_flags_t       f
    );
        logic [LEVEL_W-1:0] r;
        r = level;
        if (f.too_fast) begin
            if (level != '0) r = level - 1'b1;
        end else if (f.too_slow) begin
            if (level < LEVEL_MAX) r = level + 1'b1;
        end
        return r;
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign stop     = left_flags.below_thr || right_flags.below_thr;

    // Run latch and level update for the transaction being taken.
    always_comb begin
        run_next         = run_reg || (left_flags.above_thr && right_flags.above_thr);
        left_level_next  = left_level_reg;
        right_level_next = right_level_reg;
        if (run_next) begin
            if (stop) begin
                left_level_next  = '0;
                right_level_next = '0;
            end else begin
                left_level_next  = step_level(left_level_reg, left_flags);
                right_level_next = step_level(right_level_reg, right_flags);
            end
        end
    end

    // Control state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg         <= 1'b0;
            left_level_reg  <= '0;
            right_level_reg <= '0;
            valid_reg       <= 1'b0;
        end else begin
            if (take) begin
                run_reg         <= run_next;
                left_level_reg  <= left_level_next;
                right_level_reg <= right_level_next;
            end
            if (take) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload with direction inversion applied.
    always_ff @(posedge aclk) begin
        if (take) begin
            left_duty_reg  <= left_dir ? LEVEL_MAX - left_level_next : left_level_next;
            right_duty_reg <= right_dir ? LEVEL_MAX - right_level_next : right_level_next;
            running_reg    <= run_next;
        end
    end

    assign out_valid  = valid_reg;
    assign left_duty  = left_duty_reg;
    assign right_duty = right_duty_reg;
    assign running    = running_reg;

endmodule

// ===== hdl/dual_wheel_step_speed_regulator.sv =====
// Dual wheel step speed regulator: an input transaction passes the input register
// stage and then the merge output register before the result is valid; throughput
// one transaction per cycle while m_tready accepts results.
// Reset (aresetn low, synchronous) clears the run latch, both levels, all
// configuration registers and the pipeline valid bits.
// Depends on dwssr_pkg, dwssr_lane and dwssr_merge.
module dual_wheel_step_speed_regulator
    import dwssr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [15:0] left_count, [31:16] right_count
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [6:0] left_duty, [13:7] right_duty, [14] running
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [15:0]      cfg_data
);

    logic signed [SPEED_W-1:0] left_target_reg, right_target_reg, run_threshold_reg;
    logic        [TOL_W-1:0]   tolerance_reg;
    logic                      left_dir_reg, right_dir_reg;

    logic                      stage_valid_reg;
    logic signed [SPEED_W-1:0] left_speed_reg, right_speed_reg;
    logic signed [SPEED_W-1:0] left_count, right_count, right_speed;

    dwssr_flags_t       left_flags, right_flags;
    logic               merge_ready;
    logic               s_take;
    logic [LEVEL_W-1:0] left_duty, right_duty;
    logic               running;

    // Configuration writes; out-of-range indexes are ignored.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_target_reg   <= '0;
            right_target_reg  <= '0;
            tolerance_reg     <= '0;
            run_threshold_reg <= '0;
            left_dir_reg      <= 1'b0;
            right_dir_reg     <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LEFT_TARGET:   left_target_reg   <= cfg_data;
                REG_RIGHT_TARGET:  right_target_reg  <= cfg_data;
                REG_TOLERANCE:     tolerance_reg     <= cfg_data[TOL_W-1:0];
                REG_RUN_THRESHOLD: run_threshold_reg <= cfg_data;
                REG_LEFT_DIR:      left_dir_reg      <= cfg_data[0];
                REG_RIGHT_DIR:     right_dir_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Right count is negated; the most negative count saturates to the top.
    assign left_count  = s_tdata[15:0];
    assign right_count = s_tdata[31:16];
    assign right_speed = (right_count == {1'b1, {(SPEED_W-1){1'b0}}}) ?
                         {1'b0, {(SPEED_W-1){1'b1}}} : -right_count;

    // Input register stage.
    assign s_tready = !stage_valid_reg || merge_ready;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_take) begin
            stage_valid_reg <= 1'b1;
        end else if (merge_ready) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            left_speed_reg  <= left_count;
            right_speed_reg <= right_speed;
        end
    end

    // One comparison lane per wheel.
    dwssr_lane u_lane_left (
        .speed         (left_speed_reg),
        .target        (left_target_reg),
        .tolerance     (tolerance_reg),
        .run_threshold (run_threshold_reg),
        .flags         (left_flags)
    );

    dwssr_lane u_lane_right (
        .speed         (right_speed_reg),
        .target        (right_target_reg),
        .tolerance     (tolerance_reg),
        .run_threshold (run_threshold_reg),
        .flags         (right_flags)
    );

    // Merge the lanes, update state and register the result.
    dwssr_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (stage_valid_reg),
        .in_ready    (merge_ready),
        .left_flags  (left_flags),
        .right_flags (right_flags),
        .left_dir    (left_dir_reg),
        .right_dir   (right_dir_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .left_duty   (left_duty),
        .right_duty  (right_duty),
        .running     (running)
    );

    assign m_tdata = {1'b0, running, right_duty, left_duty};

endmodule
